>>> hdl/plru_pkg.sv
`timescale 1ns / 1ps

package plru_pkg;

  // default geometry
  localparam int unsigned SETS_DEF = 64;
  localparam int unsigned WAYS_DEF = 4;

  // fixed field widths of the words
  localparam int unsigned SET_IDX_W = 6;
  localparam int unsigned WAY_W     = 2;
  localparam int unsigned MASK_W    = 4;

  // operation codes
  localparam logic OP_TOUCH  = 1'b0;
  localparam logic OP_VICTIM = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic clr_we;   // write zeros at clear pointer, advance pointer
    logic capture;  // latch input word, launch tree read
    logic exec;     // resolve item: tree update and result load
  } plru_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last; // clear pointer at last set
  } plru_sts_t;

endpackage

>>> hdl/plru_ctrl.sv
`timescale 1ns / 1ps

module plru_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output plru_pkg::plru_cmd_t cmd,
  input  plru_pkg::plru_sts_t sts
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;
  logic       accept;

  // result register can take a new word
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  // commands
  assign cmd.clr_we  = (state_r == ST_CLEAR);
  assign cmd.capture = accept;
  assign cmd.exec    = (state_r == ST_EXEC) && out_free;

  // next state
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_CLEAR: begin
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (out_free) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // a new result only ever comes out of the execute step
  a_rise_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_EXEC)
    else $error("result appeared without an execute step");

  // an accepted word always moves to execute
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == ST_EXEC)
    else $error("accepted word not executed");

  // execute waits while a stalled result occupies the register
  a_exec_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC && out_valid_r && out_stall) |=> state_r == ST_EXEC && out_valid_r)
    else $error("result overwritten under stall");

endmodule

>>> hdl/plru_dpath.sv
`timescale 1ns / 1ps

module plru_dpath #(
  parameter int unsigned SETS = plru_pkg::SETS_DEF,
  parameter int unsigned WAYS = plru_pkg::WAYS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  plru_pkg::plru_cmd_t            cmd,
  output plru_pkg::plru_sts_t            sts,
  input  logic                           in_op,
  input  logic [plru_pkg::SET_IDX_W-1:0] in_set_index,
  input  logic [plru_pkg::WAY_W-1:0]     in_way,
  input  logic [plru_pkg::MASK_W-1:0]    in_valid_mask,
  output logic [plru_pkg::WAY_W-1:0]     out_evict_way
);

  localparam int unsigned ADDR_W = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned LEVELS = $clog2(WAYS + 1) - 1;  // halvings of the walk
  localparam int unsigned NODES  = (1 << LEVELS) - 1;     // node bits per set
  localparam int unsigned WV_W   = $clog2(WAYS + 1);      // holds 0..WAYS

  // tree store, one row per set
  logic [NODES-1:0] tree_mem [SETS];

  logic [ADDR_W-1:0]                clr_ptr_r;
  logic [ADDR_W-1:0]                addr_r;
  logic                             op_r;
  logic                             set_ok_r;
  logic [plru_pkg::WAY_W-1:0]       way_r;
  logic [plru_pkg::MASK_W-1:0]      vmask_r;
  logic [NODES-1:0]                 rd_tree_r;
  logic [plru_pkg::WAY_W-1:0]       victim_r;

  logic [ADDR_W-1:0]                rd_addr;
  logic                             we;
  logic [ADDR_W-1:0]                wa;
  logic [NODES-1:0]                 wd;
  logic [NODES-1:0]                 tree_upd;
  logic [NODES-1:0]                 tree_eff;
  logic                             way_ok;
  logic [WV_W-1:0]                  way_ext;
  logic [WV_W-1:0]                  t_base;
  logic [WV_W-1:0]                  half;
  logic [LEVELS-1:0]                t_node;
  logic                             t_right;
  logic [WV_W-1:0]                  v_sum;
  logic [LEVELS-1:0]                v_node;
  logic                             v_right;
  logic                             inv_hit;
  logic [WV_W-1:0]                  inv_way;
  logic [WV_W-1:0]                  victim;

  assign rd_addr = ADDR_W'(in_set_index);
  assign sts.clr_last = (32'(clr_ptr_r) == SETS - 1);

  // clear pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_ptr_r <= '0;
    end else if (cmd.clr_we && !sts.clr_last) begin
      clr_ptr_r <= clr_ptr_r + 1'b1;
    end
  end

  // input capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r     <= in_op;
      addr_r   <= rd_addr;
      set_ok_r <= (32'(in_set_index) < SETS);
      way_r    <= in_way;
      vmask_r  <= in_valid_mask;
    end
  end

  // memory: one write, one registered read held until the next capture
  always_ff @(posedge clk) begin
    if (we) begin
      tree_mem[wa] <= wd;
    end
    if (cmd.capture) begin
      rd_tree_r <= tree_mem[rd_addr];
    end
  end

  // out-of-range sets read as all zeros
  assign tree_eff = set_ok_r ? rd_tree_r : '0;
  assign way_ext  = WV_W'(way_r);
  assign way_ok   = (32'(way_r) < WAYS);

  // touch walk: each node points away from the side taken
  always_comb begin
    tree_upd = tree_eff;
    t_base   = '0;
    t_node   = '0;
    half     = '0;
    t_right  = 1'b0;
    for (int i = 0; i < LEVELS; i++) begin
      half     = WV_W'(WAYS >> (i + 1));
      t_right  = (way_ext >= t_base + half);
      tree_upd[t_node] = !t_right;
      t_node   = (t_node << 1) + (t_right ? LEVELS'(2) : LEVELS'(1));
      if (t_right) t_base = t_base + half;
    end
  end

  // victim walk: go right on a set node bit
  always_comb begin
    v_sum   = '0;
    v_node  = '0;
    v_right = 1'b0;
    for (int i = 0; i < LEVELS; i++) begin
      v_right = tree_eff[v_node];
      v_node  = (v_node << 1) + (v_right ? LEVELS'(2) : LEVELS'(1));
      if (v_right) v_sum = v_sum + WV_W'(WAYS >> (i + 1));
    end
  end

  // lowest way that is not valid; ways past the mask count as not valid
  always_comb begin
    inv_hit = 1'b0;
    inv_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (w >= plru_pkg::MASK_W || !vmask_r[w % plru_pkg::MASK_W]) begin
        inv_hit = 1'b1;
        inv_way = WV_W'(w);
      end
    end
  end

  assign victim = inv_hit ? inv_way : v_sum;

  // write port: clear pass or touch update
  always_comb begin
    if (cmd.clr_we) begin
      we = 1'b1;
      wa = clr_ptr_r;
      wd = '0;
    end else begin
      we = cmd.exec && (op_r == plru_pkg::OP_TOUCH) && set_ok_r && way_ok;
      wa = addr_r;
      wd = tree_upd;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      victim_r <= (op_r == plru_pkg::OP_VICTIM) ? plru_pkg::WAY_W'(victim) : '0;
    end
  end

  assign out_evict_way = victim_r;

  // clear and touch never share the write port
  a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.clr_we && cmd.exec))
    else $error("clear and execute in the same cycle");

  // no word accepted during the clear pass
  a_no_capture_clr: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.clr_we && cmd.capture))
    else $error("capture during clear pass");

  // a touch result is always zero
  a_touch_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && op_r == plru_pkg::OP_TOUCH) |=> victim_r == '0)
    else $error("touch returned a nonzero way");

endmodule

>>> hdl/tree_plru_replacement.sv
`timescale 1ns / 1ps
// Tree pseudo-LRU state, one tree per set, kept in a single-port-write memory.
// An accepted word is captured with its tree read, then resolved in the execute state
// into the result register that offers it on out_*. One word is taken at a time (tree
// read, then update/write back), and execute waits while a stalled result holds the
// output register. Reset (rst_n low, synchronous) starts a clear pass over every set
// that zeroes every tree; in_stall stays high until the pass is done.
module tree_plru_replacement #(
  parameter int unsigned SETS = plru_pkg::SETS_DEF,
  parameter int unsigned WAYS = plru_pkg::WAYS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_op,
  input  logic [plru_pkg::SET_IDX_W-1:0] in_set_index,
  input  logic [plru_pkg::WAY_W-1:0]     in_way,
  input  logic [plru_pkg::MASK_W-1:0]    in_valid_mask,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [plru_pkg::WAY_W-1:0]     out_evict_way
);

  plru_pkg::plru_cmd_t cmd;
  plru_pkg::plru_sts_t sts;

  // control
  plru_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // tree store and walks
  plru_dpath #(
    .SETS (SETS),
    .WAYS (WAYS)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_op         (in_op),
    .in_set_index  (in_set_index),
    .in_way        (in_way),
    .in_valid_mask (in_valid_mask),
    .out_evict_way (out_evict_way)
  );

endmodule

>>> dv/tree_plru_replacement_tb.sv
`timescale 1ns / 1ps

module tree_plru_replacement_tb;

  localparam int unsigned N_SETS       = plru_pkg::SETS_DEF;
  localparam int unsigned RAND_PER_PH  = 170;
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned HOLD_CYCLES  = 80;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic                           op;
    logic [plru_pkg::SET_IDX_W-1:0] set_index;
    logic [plru_pkg::WAY_W-1:0]     way;
    logic [plru_pkg::MASK_W-1:0]    valid_mask;
  } plru_word_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic                           in_op = plru_pkg::OP_TOUCH;
  logic [plru_pkg::SET_IDX_W-1:0] in_set_index = '0;
  logic [plru_pkg::WAY_W-1:0]     in_way = '0;
  logic [plru_pkg::MASK_W-1:0]    in_valid_mask = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [plru_pkg::WAY_W-1:0]     out_evict_way;

  // pending input words and victim ways still owed by the block
  plru_word_t                 pend_q[$];
  logic [plru_pkg::WAY_W-1:0] victim_due_q[$];

  // shadow copy of the per-set trees
  logic [2:0] tree_state [N_SETS];

  idle_mode_t idle_mode = IDLE_NONE;
  bit         hold_start = 1'b0;
  int         errors = 0;
  int         n_touch = 0;
  int         n_query = 0;
  int         n_walk = 0;
  int         n_checked = 0;
  int         quiet = 0;

  always #4 clk = ~clk;

  tree_plru_replacement dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_op         (in_op),
    .in_set_index  (in_set_index),
    .in_way        (in_way),
    .in_valid_mask (in_valid_mask),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_evict_way (out_evict_way)
  );

  initial begin
    for (int s = 0; s < N_SETS; s++) tree_state[s] = '0;
  end

  // apply one word to the shadow trees, return the way the block should report
  function automatic logic [plru_pkg::WAY_W-1:0] plru_update_and_pick(input plru_word_t w);
    logic [2:0]                 t;
    logic [plru_pkg::WAY_W-1:0] v;
    t = tree_state[w.set_index];
    v = '0;
    if (w.op == plru_pkg::OP_TOUCH) begin
      // root points away from the half taken, then the leaf-level node
      t[0] = ~w.way[1];
      if (w.way[1]) t[2] = ~w.way[0];
      else t[1] = ~w.way[0];
      tree_state[w.set_index] = t;
    end else if (w.valid_mask != '1) begin
      // lowest invalid way wins
      for (int i = plru_pkg::MASK_W - 1; i >= 0; i--) begin
        if (!w.valid_mask[i]) v = plru_pkg::WAY_W'(i);
      end
    end else begin
      // all valid: follow node bits, 1 = go right
      v[1] = t[0];
      v[0] = t[0] ? t[2] : t[1];
    end
    return v;
  endfunction

  function automatic bit sender_idles();
    case (idle_mode)
      IDLE_SEND: return $urandom_range(99) < 60;
      IDLE_BOTH: return $urandom_range(99) < 22;
      default:   return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stalls();
    case (idle_mode)
      IDLE_RECV: return $urandom_range(99) < 60;
      IDLE_BOTH: return $urandom_range(99) < 22;
      default:   return 1'b0;
    endcase
  endfunction

  // driver: hold a stalled word, otherwise maybe present the next one
  always @(posedge clk) begin : drive
    plru_word_t cur;
    plru_word_t nxt;
    logic       take;
    logic       nv;
    cur  = {in_op, in_set_index, in_way, in_valid_mask};
    take = in_valid && !in_stall;
    if (take) begin
      victim_due_q.push_back(plru_update_and_pick(cur));
      if (cur.op == plru_pkg::OP_TOUCH) n_touch++;
      else begin
        n_query++;
        if (cur.valid_mask == '1) n_walk++;
      end
    end
    nv  = in_valid && !take;
    nxt = cur;
    if (!nv && rst_n && pend_q.size() > 0 && !sender_idles()) begin
      nxt = pend_q.pop_front();
      nv  = 1'b1;
    end
    in_valid      <= nv;
    in_op         <= nxt.op;
    in_set_index  <= nxt.set_index;
    in_way        <= nxt.way;
    in_valid_mask <= nxt.valid_mask;
  end

  // monitor: check each accepted result word, drive out_stall
  always @(posedge clk) begin : collect
    int                         hold_cnt;
    bit                         hold_seen;
    logic [plru_pkg::WAY_W-1:0] want;
    if (out_valid && !out_stall) begin
      if (victim_due_q.size() == 0) begin
        $display("%0t: unexpected result word, evict way %0d", $time, out_evict_way);
        errors++;
      end else begin
        want = victim_due_q.pop_front();
        n_checked++;
        if (out_evict_way !== want) begin
          $display("%0t: evict way mismatch, expected %0d, got %0d",
                   $time, want, out_evict_way);
          errors++;
        end
      end
    end
    // one long hold-off so the block backs up into its input
    if (hold_start && !hold_seen) begin
      hold_seen = 1'b1;
      hold_cnt  = HOLD_CYCLES;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= receiver_stalls();
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("%0t: timeout, no word moved for %0d cycles", $time, quiet);
      $display("** tree_plru_replacement: FAILED **");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic push_word(input logic op, input int set_i, input int way_i,
                           input int mask_i);
    plru_word_t w;
    w.op         = op;
    w.set_index  = plru_pkg::SET_IDX_W'(set_i);
    w.way        = plru_pkg::WAY_W'(way_i);
    w.valid_mask = plru_pkg::MASK_W'(mask_i);
    pend_q.push_back(w);
  endtask

  // random word: mostly a few busy sets, mostly full masks on queries
  task automatic push_random();
    int hot_sets[4];
    int s;
    hot_sets = '{3, 17, 42, 63};
    s = ($urandom_range(99) < 70) ? hot_sets[$urandom_range(3)] : $urandom_range(63);
    if ($urandom_range(1)) begin
      push_word(plru_pkg::OP_VICTIM, s, $urandom_range(3),
                ($urandom_range(99) < 60) ? 15 : $urandom_range(15));
    end else begin
      push_word(plru_pkg::OP_TOUCH, s, $urandom_range(3), $urandom_range(15));
    end
  endtask

  task automatic wait_drain();
    do @(negedge clk);
    while (pend_q.size() > 0 || in_valid || victim_due_q.size() > 0);
  endtask

  initial begin
    idle_mode_t plan[5];
    plan = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH, IDLE_NONE};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: cleared trees, every touch path, mask priorities, field extremes
    push_word(plru_pkg::OP_VICTIM, 0, 3, 15);
    push_word(plru_pkg::OP_VICTIM, 63, 0, 15);
    push_word(plru_pkg::OP_TOUCH, 5, 0, 15);
    push_word(plru_pkg::OP_VICTIM, 5, 0, 15);
    push_word(plru_pkg::OP_TOUCH, 5, 1, 0);
    push_word(plru_pkg::OP_VICTIM, 5, 3, 15);
    push_word(plru_pkg::OP_TOUCH, 5, 2, 7);
    push_word(plru_pkg::OP_VICTIM, 5, 0, 15);
    push_word(plru_pkg::OP_TOUCH, 5, 3, 0);
    push_word(plru_pkg::OP_VICTIM, 5, 1, 15);
    push_word(plru_pkg::OP_VICTIM, 5, 0, 0);
    push_word(plru_pkg::OP_VICTIM, 5, 3, 14);
    push_word(plru_pkg::OP_VICTIM, 5, 0, 13);
    push_word(plru_pkg::OP_VICTIM, 5, 0, 11);
    push_word(plru_pkg::OP_VICTIM, 5, 0, 7);
    push_word(plru_pkg::OP_TOUCH, 63, 3, 15);
    push_word(plru_pkg::OP_VICTIM, 63, 2, 15);
    push_word(plru_pkg::OP_TOUCH, 63, 0, 15);
    push_word(plru_pkg::OP_VICTIM, 63, 0, 15);
    push_word(plru_pkg::OP_VICTIM, 4, 0, 15);
    push_word(plru_pkg::OP_TOUCH, 0, 3, 0);
    push_word(plru_pkg::OP_VICTIM, 0, 0, 15);
    wait_drain();

    // random phases with different idling on each side
    foreach (plan[p]) begin
      idle_mode = plan[p];
      for (int k = 0; k < RAND_PER_PH; k++) push_random();
      if (p == 0) hold_start = 1'b1;
      wait_drain();
    end

    repeat (6) @(posedge clk);
    $display("Covered %0d touches and %0d victim queries (%0d tree walks), %0d checked,",
             n_touch, n_query, n_walk, n_checked);
    $display("under no idling, sender gaps, receiver stalls, both, and one long hold-off.");
    if (errors == 0 && victim_due_q.size() == 0) begin
      $display("** tree_plru_replacement: PASSED **");
    end else begin
      $display("** tree_plru_replacement: FAILED **");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/plru_pkg.sv
hdl/plru_ctrl.sv
hdl/plru_dpath.sv
hdl/tree_plru_replacement.sv
dv/tree_plru_replacement_tb.sv
